// ===== hdl/mep_pkg.sv =====
// Shared types, constants and helper functions for the escape-time pixel block.
// Used by every module in this folder; depends on nothing.
package mep_pkg;

  localparam int FRAC_BITS = 28;
  localparam int MAX_SIDE = 4096;
  localparam int COORD_W = 32;
  localparam int IDX_W = 12;
  localparam int SIDE_W = 13;
  localparam int CNT_W = 16;
  localparam int GRAY_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam int SPAN_W = COORD_W + 1;
  localparam int PROD_W = SPAN_W + IDX_W + 1;
  localparam int MAG_W = PROD_W - 2;
  localparam int REM_W = SIDE_W - 1;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int WIDE_W = 48;
  localparam int SQ_W = 2 * COORD_W - 1 - FRAC_BITS;
  localparam int XY_W = 2 * COORD_W - (FRAC_BITS - 1);
  localparam int GNUM_W = CNT_W + GRAY_W;
  localparam int GSTEP_W = $clog2(GRAY_W);

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

  localparam logic signed [COORD_W-1:0] RST_X_MIN = -32'sd1073741824;
  localparam logic signed [COORD_W-1:0] RST_X_MAX = 32'sd1073741824;
  localparam logic signed [COORD_W-1:0] RST_Y_MIN = -32'sd1073741824;
  localparam logic signed [COORD_W-1:0] RST_Y_MAX = 32'sd1073741824;
  localparam logic [SIDE_W-1:0] RST_COLUMNS = 13'd512;
  localparam logic [SIDE_W-1:0] RST_ROWS = 13'd512;
  localparam logic [CNT_W-1:0] RST_MAX_ITER = 16'd1000;

  localparam logic [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(4) << FRAC_BITS;
  localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);
  localparam logic signed [WIDE_W-1:0] Q_MAX = 48'sd2147483647;
  localparam logic signed [WIDE_W-1:0] Q_MIN = -48'sd2147483648;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_max;
    logic [SIDE_W-1:0] columns;
    logic [SIDE_W-1:0] rows;
    logic [CNT_W-1:0] max_iter;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } point_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[COORD_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/mep_front.sv =====
// Front end: accepts a pixel and maps column and row into the complex window.
// One shared bit-serial divider scales both axes. Depends on mep_pkg.
module mep_front (
  input  logic clk,
  input  logic rst,
  input  mep_pkg::cfg_t cfg,
  input  logic pixel_valid,
  output logic pixel_stall,
  input  logic [mep_pkg::IDX_W-1:0] pixel_col,
  input  logic [mep_pkg::IDX_W-1:0] pixel_row,
  output logic push_valid,
  input  logic push_stall,
  output mep_pkg::point_t push_item
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL = 3'd1;
  localparam logic [2:0] F_DIV = 3'd2;
  localparam logic [2:0] F_FIN = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0] state;
  logic axis;
  logic [mep_pkg::IDX_W-1:0] col;
  logic [mep_pkg::IDX_W-1:0] row;
  logic signed [mep_pkg::COORD_W-1:0] cx;
  logic signed [mep_pkg::COORD_W-1:0] cy;
  logic neg;
  logic [mep_pkg::MAG_W-1:0] dq;
  logic [mep_pkg::REM_W-1:0] rem;
  logic [mep_pkg::SIDE_W-1:0] dvs;
  logic [mep_pkg::STEP_W-1:0] step;

  logic signed [mep_pkg::COORD_W-1:0] lo;
  logic signed [mep_pkg::COORD_W-1:0] hi;
  logic [mep_pkg::IDX_W-1:0] idx;
  logic [mep_pkg::SIDE_W-1:0] side;
  logic [mep_pkg::SIDE_W-1:0] dvs_sel;
  logic signed [mep_pkg::SPAN_W-1:0] span;
  logic signed [mep_pkg::PROD_W-1:0] prod;
  logic signed [mep_pkg::PROD_W-1:0] mag;
  logic [mep_pkg::SIDE_W-1:0] rem_sh;
  logic signed [mep_pkg::PROD_W-1:0] quot;
  logic signed [mep_pkg::WIDE_W-1:0] sum;
  logic signed [mep_pkg::COORD_W-1:0] coord;

  always_comb begin
    lo = axis ? cfg.y_min : cfg.x_min;
    hi = axis ? cfg.y_max : cfg.x_max;
    idx = axis ? row : col;
    side = axis ? cfg.rows : cfg.columns;
    if (side == '0) begin
      dvs_sel = mep_pkg::SIDE_W'(1);
    end else if (side > mep_pkg::SIDE_LIMIT) begin
      dvs_sel = mep_pkg::SIDE_LIMIT;
    end else begin
      dvs_sel = side;
    end
    span = mep_pkg::SPAN_W'(hi) - mep_pkg::SPAN_W'(lo);
    prod = mep_pkg::PROD_W'(span) * $signed({1'b0, idx});
    mag = prod[mep_pkg::PROD_W-1] ? -prod : prod;
    rem_sh = {rem, dq[mep_pkg::MAG_W-1]};
    quot = neg ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
    sum = mep_pkg::WIDE_W'(lo) + mep_pkg::WIDE_W'(quot);
    coord = mep_pkg::sat32(sum);
  end

  assign pixel_stall = (state != F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_item.col = col;
  assign push_item.row = row;
  assign push_item.cx = cx;
  assign push_item.cy = cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      axis <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (pixel_valid) begin
            col <= pixel_col;
            row <= pixel_row;
            axis <= 1'b0;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          neg <= prod[mep_pkg::PROD_W-1];
          dq <= mag[mep_pkg::MAG_W-1:0];
          rem <= '0;
          dvs <= dvs_sel;
          step <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          if (rem_sh >= dvs) begin
            rem <= mep_pkg::REM_W'(rem_sh - dvs);
            dq <= {dq[mep_pkg::MAG_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[mep_pkg::REM_W-1:0];
            dq <= {dq[mep_pkg::MAG_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == mep_pkg::STEP_W'(mep_pkg::MAG_W - 1)) begin
            state <= F_FIN;
          end
        end
        F_FIN: begin
          if (!axis) begin
            cx <= coord;
            axis <= 1'b1;
            state <= F_MUL;
          end else begin
            cy <= coord;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!push_stall) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mep_queue.sv =====
// Two-entry queue of mapped points between the front and back ends.
// Depends on mep_pkg for the entry type.
module mep_queue (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_stall,
  input  mep_pkg::point_t push_item,
  output logic pop_valid,
  input  logic pop_take,
  output mep_pkg::point_t pop_item
);

  mep_pkg::point_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic do_push;
  logic do_pop;

  assign push_stall = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_item = entries[rd_ptr];
  assign do_push = push_valid && !push_stall;
  assign do_pop = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/mep_back.sv =====
// Back end: runs the escape iteration for one point, scales the gray level
// and holds the result item in the output register. Depends on mep_pkg.
module mep_back (
  input  logic clk,
  input  logic rst,
  input  mep_pkg::cfg_t cfg,
  input  logic pop_valid,
  output logic pop_take,
  input  mep_pkg::point_t pop_item,
  output logic result_valid,
  input  logic result_stall,
  output logic [mep_pkg::IDX_W-1:0] out_col,
  output logic [mep_pkg::IDX_W-1:0] out_row,
  output logic [mep_pkg::CNT_W-1:0] escape_count,
  output logic [mep_pkg::GRAY_W-1:0] gray_level
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL = 3'd1;
  localparam logic [2:0] B_UPD = 3'd2;
  localparam logic [2:0] B_GRAY = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  logic [2:0] state;
  logic [mep_pkg::IDX_W-1:0] col;
  logic [mep_pkg::IDX_W-1:0] row;
  logic signed [mep_pkg::COORD_W-1:0] cx;
  logic signed [mep_pkg::COORD_W-1:0] cy;
  logic signed [mep_pkg::COORD_W-1:0] x;
  logic signed [mep_pkg::COORD_W-1:0] y;
  logic [mep_pkg::CNT_W-1:0] count;
  logic [mep_pkg::SQ_W-1:0] pxx;
  logic [mep_pkg::SQ_W-1:0] pyy;
  logic signed [mep_pkg::XY_W-1:0] pxy;
  logic [mep_pkg::GNUM_W-1:0] grem;
  logic [mep_pkg::GNUM_W-1:0] gdiv;
  logic [mep_pkg::GRAY_W-1:0] gq;
  logic [mep_pkg::GSTEP_W-1:0] gstep;

  logic signed [2*mep_pkg::COORD_W-1:0] sq_x;
  logic signed [2*mep_pkg::COORD_W-1:0] sq_y;
  logic signed [2*mep_pkg::COORD_W-1:0] xy_prod;
  logic [mep_pkg::SQ_W:0] mag_sum;
  logic signed [mep_pkg::WIDE_W-1:0] nx_wide;
  logic signed [mep_pkg::WIDE_W-1:0] ny_wide;
  logic [mep_pkg::GNUM_W-1:0] gnum;
  logic out_free;

  always_comb begin
    sq_x = x * x;
    sq_y = y * y;
    xy_prod = x * y;
    mag_sum = {1'b0, pxx} + {1'b0, pyy};
    nx_wide = $signed(mep_pkg::WIDE_W'(pxx)) - $signed(mep_pkg::WIDE_W'(pyy))
              + mep_pkg::WIDE_W'(cx);
    ny_wide = mep_pkg::WIDE_W'(pxy) + mep_pkg::WIDE_W'(cy);
    gnum = {count, mep_pkg::GRAY_W'(0)} - mep_pkg::GNUM_W'(count);
  end

  assign pop_take = (state == B_IDLE);
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != B_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            col <= pop_item.col;
            row <= pop_item.row;
            cx <= pop_item.cx;
            cy <= pop_item.cy;
            x <= pop_item.cx;
            y <= pop_item.cy;
            count <= '0;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          if (count >= cfg.max_iter) begin
            grem <= gnum;
            gdiv <= {1'b0, cfg.max_iter, (mep_pkg::GRAY_W - 1)'(0)};
            gq <= '0;
            gstep <= '0;
            state <= B_GRAY;
          end else begin
            pxx <= sq_x[2*mep_pkg::COORD_W-2:mep_pkg::FRAC_BITS];
            pyy <= sq_y[2*mep_pkg::COORD_W-2:mep_pkg::FRAC_BITS];
            pxy <= xy_prod[2*mep_pkg::COORD_W-1:mep_pkg::FRAC_BITS-1];
            state <= B_UPD;
          end
        end
        B_UPD: begin
          if (mag_sum > mep_pkg::ESCAPE_LIMIT) begin
            grem <= gnum;
            gdiv <= {1'b0, cfg.max_iter, (mep_pkg::GRAY_W - 1)'(0)};
            gq <= '0;
            gstep <= '0;
            state <= B_GRAY;
          end else begin
            x <= mep_pkg::sat32(nx_wide);
            y <= mep_pkg::sat32(ny_wide);
            count <= count + 1'b1;
            state <= B_MUL;
          end
        end
        B_GRAY: begin
          if (grem >= gdiv) begin
            grem <= grem - gdiv;
            gq <= {gq[mep_pkg::GRAY_W-2:0], 1'b1};
          end else begin
            gq <= {gq[mep_pkg::GRAY_W-2:0], 1'b0};
          end
          gdiv <= gdiv >> 1;
          gstep <= gstep + 1'b1;
          if (gstep == mep_pkg::GSTEP_W'(mep_pkg::GRAY_W - 1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_col <= col;
            out_row <= row;
            escape_count <= count;
            gray_level <= (cfg.max_iter == '0) ? '0 : gq;
            result_valid <= 1'b1;
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mandelbrot_escape_pixel.sv =====
// Top level of the escape-time pixel block: configuration registers, front end,
// point queue and back end. Depends on mep_pkg, mep_front, mep_queue, mep_back.
//
//   channel   handshake              payload
//   pixel     pixel_valid/stall      pixel_col, pixel_row
//   result    result_valid/stall     out_col, out_row, escape_count, gray_level
//   config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// The front end maps a pixel with its bit-serial divider, which is shared by
// both axes; then the item waits in a two-entry queue.
// In the back end each escape iteration passes through a multiply state and
// an update state; then the gray level takes 8 gray steps.
// Reset clears the control state and loads the register defaults.
// A stalled result holds in the output register while the back end already
// takes the next point from the queue.
module mandelbrot_escape_pixel (
  input  logic clk,
  input  logic rst,
  input  logic pixel_valid,
  output logic pixel_stall,
  input  logic [mep_pkg::IDX_W-1:0] pixel_col,
  input  logic [mep_pkg::IDX_W-1:0] pixel_row,
  output logic result_valid,
  input  logic result_stall,
  output logic [mep_pkg::IDX_W-1:0] out_col,
  output logic [mep_pkg::IDX_W-1:0] out_row,
  output logic [mep_pkg::CNT_W-1:0] escape_count,
  output logic [mep_pkg::GRAY_W-1:0] gray_level,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mep_pkg::COORD_W-1:0] cfg_data
);

  mep_pkg::cfg_t cfg;
  mep_pkg::point_t push_item;
  mep_pkg::point_t pop_item;
  logic push_valid;
  logic push_stall;
  logic pop_valid;
  logic pop_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_min <= mep_pkg::RST_X_MIN;
      cfg.x_max <= mep_pkg::RST_X_MAX;
      cfg.y_min <= mep_pkg::RST_Y_MIN;
      cfg.y_max <= mep_pkg::RST_Y_MAX;
      cfg.columns <= mep_pkg::RST_COLUMNS;
      cfg.rows <= mep_pkg::RST_ROWS;
      cfg.max_iter <= mep_pkg::RST_MAX_ITER;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mep_pkg::REG_X_MIN: cfg.x_min <= cfg_data;
        mep_pkg::REG_X_MAX: cfg.x_max <= cfg_data;
        mep_pkg::REG_Y_MIN: cfg.y_min <= cfg_data;
        mep_pkg::REG_Y_MAX: cfg.y_max <= cfg_data;
        mep_pkg::REG_COLUMNS: cfg.columns <= cfg_data[mep_pkg::SIDE_W-1:0];
        mep_pkg::REG_ROWS: cfg.rows <= cfg_data[mep_pkg::SIDE_W-1:0];
        mep_pkg::REG_MAX_ITER: cfg.max_iter <= cfg_data[mep_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mep_front u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_col(pixel_col),
    .pixel_row(pixel_row),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_item(push_item)
  );

  mep_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_stall(push_stall),
    .push_item(push_item),
    .pop_valid(pop_valid),
    .pop_take(pop_take),
    .pop_item(pop_item)
  );

  mep_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pop_valid(pop_valid),
    .pop_take(pop_take),
    .pop_item(pop_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_col(out_col),
    .out_row(out_row),
    .escape_count(escape_count),
    .gray_level(gray_level)
  );

endmodule

// ===== tb/mep_escape_checker.sv =====
`timescale 1ns / 100ps
// Checker for the escape-time pixel block: tracks the configuration registers, predicts
// count and gray level for every pixel taken and compares the results. Depends on mep_pkg.
module mep_escape_checker (
  input  logic clk,
  input  logic rst,
  input  logic pixel_valid,
  input  logic pixel_stall,
  input  logic [mep_pkg::IDX_W-1:0] pixel_col,
  input  logic [mep_pkg::IDX_W-1:0] pixel_row,
  input  logic result_valid,
  input  logic result_stall,
  input  logic [mep_pkg::IDX_W-1:0] out_col,
  input  logic [mep_pkg::IDX_W-1:0] out_row,
  input  logic [mep_pkg::CNT_W-1:0] escape_count,
  input  logic [mep_pkg::GRAY_W-1:0] gray_level,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mep_pkg::COORD_W-1:0] cfg_data,
  output int failures,
  output int pending
);

  typedef struct packed {
    logic [mep_pkg::IDX_W-1:0] col;
    logic [mep_pkg::IDX_W-1:0] row;
    logic [mep_pkg::CNT_W-1:0] count;
    logic [mep_pkg::GRAY_W-1:0] gray;
  } escape_result_t;

  localparam longint ESCAPE_RADIUS_SQ = longint'(4) << mep_pkg::FRAC_BITS;

  logic signed [mep_pkg::COORD_W-1:0] win_x_min, win_x_max, win_y_min, win_y_max;
  logic [mep_pkg::SIDE_W-1:0] img_cols, img_rows;
  logic [mep_pkg::CNT_W-1:0] iter_limit;
  escape_result_t expected_pixels[$];
  escape_result_t got, want;

  function automatic logic signed [mep_pkg::COORD_W-1:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[mep_pkg::COORD_W-1:0];
  endfunction

  function automatic logic signed [mep_pkg::COORD_W-1:0] plane_coord(
    input logic signed [mep_pkg::COORD_W-1:0] lo,
    input logic signed [mep_pkg::COORD_W-1:0] hi,
    input logic [mep_pkg::IDX_W-1:0] idx,
    input logic [mep_pkg::SIDE_W-1:0] side
  );
    longint span, divisor;
    span = longint'(hi) - longint'(lo);
    if (side == 0) begin
      divisor = 1;
    end else if (side > mep_pkg::MAX_SIDE) begin
      divisor = mep_pkg::MAX_SIDE;
    end else begin
      divisor = longint'(side);
    end
    return clamp_q(longint'(lo) + (span * longint'({52'd0, idx})) / divisor);
  endfunction

  function automatic escape_result_t escape_time(input logic [mep_pkg::IDX_W-1:0] col,
                                                 input logic [mep_pkg::IDX_W-1:0] row);
    escape_result_t r;
    longint cx, cy, x, y, xx, yy, xy2;
    int count;
    bit escaped;
    cx = plane_coord(win_x_min, win_x_max, col, img_cols);
    cy = plane_coord(win_y_min, win_y_max, row, img_rows);
    x = cx;
    y = cy;
    count = 0;
    escaped = 1'b0;
    while (!escaped && count < int'(iter_limit)) begin
      xx = (x * x) >>> mep_pkg::FRAC_BITS;
      yy = (y * y) >>> mep_pkg::FRAC_BITS;
      if (xx + yy > ESCAPE_RADIUS_SQ) begin
        escaped = 1'b1;
      end else begin
        xy2 = (x * y) >>> (mep_pkg::FRAC_BITS - 1);
        x = clamp_q(xx - yy + cx);
        y = clamp_q(xy2 + cy);
        count++;
      end
    end
    r.col = col;
    r.row = row;
    r.count = count[mep_pkg::CNT_W-1:0];
    r.gray = (iter_limit == 0) ? '0 :
             mep_pkg::GRAY_W'((255 * count) / int'(iter_limit));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      win_x_min = mep_pkg::RST_X_MIN;
      win_x_max = mep_pkg::RST_X_MAX;
      win_y_min = mep_pkg::RST_Y_MIN;
      win_y_max = mep_pkg::RST_Y_MAX;
      img_cols = mep_pkg::RST_COLUMNS;
      img_rows = mep_pkg::RST_ROWS;
      iter_limit = mep_pkg::RST_MAX_ITER;
      expected_pixels.delete();
      failures = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mep_pkg::REG_X_MIN: win_x_min = cfg_data;
          mep_pkg::REG_X_MAX: win_x_max = cfg_data;
          mep_pkg::REG_Y_MIN: win_y_min = cfg_data;
          mep_pkg::REG_Y_MAX: win_y_max = cfg_data;
          mep_pkg::REG_COLUMNS: img_cols = cfg_data[mep_pkg::SIDE_W-1:0];
          mep_pkg::REG_ROWS: img_rows = cfg_data[mep_pkg::SIDE_W-1:0];
          mep_pkg::REG_MAX_ITER: iter_limit = cfg_data[mep_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (pixel_valid && !pixel_stall) begin
        expected_pixels.push_back(escape_time(pixel_col, pixel_row));
      end
      if (result_valid && !result_stall) begin
        got = {out_col, out_row, escape_count, gray_level};
        if (expected_pixels.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: unexpected item col %0d row %0d count %0d gray %0d",
                     $realtime, got.col, got.row, got.count, got.gray);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.col != want.col || got.row != want.row || got.count != want.count ||
              got.gray != want.gray) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: col row count gray expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                       $realtime, want.col, want.row, want.count, want.gray,
                       got.col, got.row, got.count, got.gray);
            end
          end
        end
      end
      pending <= expected_pixels.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the escape-time pixel regression: clock, reset, pixel and register stimulus,
// result stalls and the verdict. Depends on mep_pkg, mandelbrot_escape_pixel, mep_escape_checker.
module testbench;

  typedef enum int {WIN_VIEW, WIN_ZOOM, WIN_WILD} window_kind_t;

  localparam logic [mep_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int Q_ONE = 1 << mep_pkg::FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic [mep_pkg::IDX_W-1:0] pixel_col = '0;
  logic [mep_pkg::IDX_W-1:0] pixel_row = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [mep_pkg::IDX_W-1:0] out_col, out_row;
  logic [mep_pkg::CNT_W-1:0] escape_count;
  logic [mep_pkg::GRAY_W-1:0] gray_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mep_pkg::COORD_W-1:0] cfg_data = '0;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int failures, pending;
  logic [mep_pkg::SIDE_W-1:0] cur_cols = mep_pkg::RST_COLUMNS;
  logic [mep_pkg::SIDE_W-1:0] cur_rows = mep_pkg::RST_ROWS;

  mandelbrot_escape_pixel u_top (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_col(out_col), .out_row(out_row),
    .escape_count(escape_count), .gray_level(gray_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mep_escape_checker u_checker (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_col(out_col), .out_row(out_row),
    .escape_count(escape_count), .gray_level(gray_level),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mandelbrot_escape_pixel regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      result_stall <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(1, 13);
    end
  end

  task automatic send_pixel(input logic [mep_pkg::IDX_W-1:0] col,
                            input logic [mep_pkg::IDX_W-1:0] row);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [mep_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mep_pkg::COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_window(input int x0, input int x1, input int y0, input int y1,
                                input logic [mep_pkg::SIDE_W-1:0] cols,
                                input logic [mep_pkg::SIDE_W-1:0] rows,
                                input logic [mep_pkg::CNT_W-1:0] iters);
    cfg_write(mep_pkg::REG_X_MIN, x0);
    cfg_write(mep_pkg::REG_X_MAX, x1);
    cfg_write(mep_pkg::REG_Y_MIN, y0);
    cfg_write(mep_pkg::REG_Y_MAX, y1);
    cfg_write(mep_pkg::REG_COLUMNS, ($urandom() & 32'hFFFF_E000) | cols);
    cfg_write(mep_pkg::REG_ROWS, ($urandom() & 32'hFFFF_E000) | rows);
    cfg_write(mep_pkg::REG_MAX_ITER, ($urandom() & 32'hFFFF_0000) | iters);
    cfg_valid <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
  endtask

  function automatic logic [mep_pkg::IDX_W-1:0] pick_index(
    input logic [mep_pkg::SIDE_W-1:0] side
  );
    int top_idx;
    top_idx = (side > mep_pkg::MAX_SIDE) ? mep_pkg::MAX_SIDE - 1 : int'(side) - 1;
    if (side != 0 && $urandom_range(0, 9) < 7) begin
      return mep_pkg::IDX_W'($urandom_range(0, top_idx));
    end
    return mep_pkg::IDX_W'($urandom_range(0, 4095));
  endfunction

  initial begin
    int phase, n, cxc, cyc, w, x0, x1, y0, y1;
    window_kind_t kind;
    logic [mep_pkg::SIDE_W-1:0] cols, rows;
    logic [mep_pkg::CNT_W-1:0] iters;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(256, 256);
    send_pixel(128, 256);
    send_pixel(384, 256);
    send_pixel(256, 384);
    send_pixel(511, 0);
    send_pixel(0, 511);
    pixel_valid <= 1'b0;

    // Extreme window with a reversed y axis; zero and oversized image sides.
    wait_drained();
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    program_window(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   13'd0, 13'd8191, 16'hFFFF);
    send_pixel(0, 0);
    send_pixel(1, 4095);
    send_pixel(4095, 1);
    send_pixel(1, 0);
    send_pixel(4095, 4095);
    pixel_valid <= 1'b0;

    wait_drained();
    program_window(0, 0, 0, 0, 13'd4096, 13'd1, 16'hFFFF);
    send_pixel(7, 3);
    pixel_valid <= 1'b0;

    wait_drained();
    program_window(0, 0, 0, 0, 13'd4096, 13'd1, 16'd0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    pixel_valid <= 1'b0;

    wait_drained();
    program_window(mep_pkg::RST_X_MIN, mep_pkg::RST_X_MAX, mep_pkg::RST_Y_MIN,
                   mep_pkg::RST_Y_MAX, mep_pkg::RST_COLUMNS, mep_pkg::RST_ROWS, 16'd1);
    send_pixel(0, 0);
    send_pixel(256, 256);
    send_pixel(4095, 4095);
    pixel_valid <= 1'b0;

    for (phase = 0; phase < 10; phase++) begin
      kind = window_kind_t'(phase % 3);
      iters = (phase == 4) ? mep_pkg::CNT_W'($urandom_range(200, 300)) :
              mep_pkg::CNT_W'($urandom_range(1, 64));
      case (kind)
        WIN_VIEW: begin
          x0 = -2 * Q_ONE + int'($urandom_range(0, Q_ONE));
          x1 = int'($urandom_range(0, Q_ONE));
          y0 = -int'($urandom_range(Q_ONE / 2, Q_ONE + Q_ONE / 2));
          y1 = int'($urandom_range(Q_ONE / 2, Q_ONE + Q_ONE / 2));
          cols = mep_pkg::SIDE_W'($urandom_range(1, 800));
          rows = mep_pkg::SIDE_W'($urandom_range(1, 800));
        end
        WIN_ZOOM: begin
          cxc = -(3 * Q_ONE / 4) + int'($urandom_range(0, Q_ONE / 8));
          cyc = int'($urandom_range(0, Q_ONE / 2));
          w = int'($urandom_range(1, 1 << 20));
          x0 = cxc - w;
          x1 = cxc + w;
          y0 = cyc - w;
          y1 = cyc + w;
          cols = mep_pkg::SIDE_W'($urandom_range(16, 4096));
          rows = mep_pkg::SIDE_W'($urandom_range(16, 4096));
        end
        default: begin
          x0 = $urandom();
          x1 = $urandom();
          y0 = $urandom();
          y1 = $urandom();
          cols = mep_pkg::SIDE_W'($urandom_range(0, 8191));
          rows = mep_pkg::SIDE_W'($urandom_range(0, 8191));
        end
      endcase
      gaps_on = (phase != 9) && ($urandom_range(0, 3) != 0);
      stalls_on = (phase != 9) && ($urandom_range(0, 3) != 0);
      wait_drained();
      program_window(x0, x1, y0, y1, cols, rows, iters);
      for (n = 0; n < 60; n++) begin
        if (phase != 9 && n == 30) begin
          gaps_on = !gaps_on;
          stalls_on = !stalls_on;
        end
        send_pixel(pick_index(cur_cols), pick_index(cur_rows));
      end
      pixel_valid <= 1'b0;
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("mandelbrot_escape_pixel regression: pass");
    end else begin
      $display("mandelbrot_escape_pixel regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mep_pkg.sv
hdl/mep_front.sv
hdl/mep_queue.sv
hdl/mep_back.sv
hdl/mandelbrot_escape_pixel.sv
tb/mep_escape_checker.sv
tb/testbench.sv
